// ===== rtl/msrt_pkg.sv =====
// ----------------------------------------------------------------------------
// msrt_pkg: shared types and constants of the mask sorted route table
// holds the table depth, operation codes, entry type and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none
package msrt_pkg;
   localparam int TableDepth = 32;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int EntryW = 104;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_FLUSH  = 2'd3
   } func_type;

   typedef struct packed {
      logic [31:0] target;
      logic [31:0] gateway;
      logic [31:0] mask;
      logic [7:0]  ttl;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/mask_sorted_route_table.sv =====
// ----------------------------------------------------------------------------
// mask_sorted_route_table: route table sorted by mask with prefix lookup
// Routes sit in one ram, kept in descending mask order. Every request gives
// exactly one response. A request is taken on req_valid and req_ready; the
// result is held on the rsp_ ports until the rsp_ transfer completes, and the
// block takes no new request until then.
// The sequencer reads the slots through the ram's registered read port. A scan
// issues a read and then evaluates it for each slot visited, with a last step
// when it runs off the end of the table; a remove or insert then moves the tail
// of the table one slot at a time (read, then write), and an insert ends with
// its end check and a step placing the route. rsp_valid is registered and rises
// in the cycle after the sequencer reaches done. Flush goes straight to done,
// and the next request can be taken in the cycle after the rsp_ transfer.
// Reset clears the entry count, state, read phase and rsp_valid; the ram keeps
// stale data that is never read, so no clearing pass is needed. A stalled
// receiver holds the response and req_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none
module mask_sorted_route_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_route_target,
   input  wire logic [31:0] req_route_gateway,
   input  wire logic [31:0] req_route_mask,
   input  wire logic [7:0]  req_route_ttl,
   input  wire logic [31:0] req_dest_ip,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic             rsp_table_full,
   output logic [31:0]      rsp_found_target,
   output logic [31:0]      rsp_found_gateway,
   output logic [31:0]      rsp_found_mask,
   output logic [7:0]       rsp_found_ttl,
   output logic [5:0]       rsp_entry_count
);
   localparam int IW = msrt_pkg::IdxW;
   localparam int CW = msrt_pkg::CntW;

   msrt_pkg::state_type state_ff, state_in;
   logic                rd_phase_ff, rd_phase_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [1:0]          func_ff, func_in;
   msrt_pkg::entry_type req_ff, req_in;
   logic [31:0]         ip_ff, ip_in;
   msrt_pkg::entry_type res_ff, res_in;
   logic                hit_ff, hit_in, full_ff, full_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   msrt_pkg::entry_type wr_data, rd_data;
   logic [msrt_pkg::EntryW-1:0] rd_raw;
   logic                exact;

   msrt_ram #(.Width(msrt_pkg::EntryW), .Depth(msrt_pkg::TableDepth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_data = rd_raw;

   assign exact = (rd_data.target == req_ff.target) && (rd_data.gateway == req_ff.gateway)
                  && (rd_data.mask == req_ff.mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msrt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_phase_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_phase_ff  <= rd_phase_in;
      end
      pos_ff  <= pos_in;
      func_ff <= func_in;
      req_ff  <= req_in;
      ip_ff   <= ip_in;
      res_ff  <= res_in;
      hit_ff  <= hit_in;
      full_ff <= full_in;
   end

   always_comb begin
      state_in     = state_ff;
      rd_phase_in  = 1'b0;
      count_in     = count_ff;
      pos_in       = pos_ff;
      func_in      = func_ff;
      req_in       = req_ff;
      ip_in        = ip_ff;
      res_in       = res_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[IW-1:0];
      wr_data      = req_ff;
      rd_addr      = pos_ff[IW-1:0];
      req_ready    = 1'b0;
      unique case (state_ff)
         msrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_func;
               req_in  = '{req_route_target, req_route_gateway, req_route_mask,
                           req_route_ttl};
               ip_in   = req_dest_ip;
               pos_in  = '0;
               res_in  = '0;
               hit_in  = 1'b0;
               full_in = 1'b0;
               if (msrt_pkg::func_type'(req_func) == msrt_pkg::FUNC_FLUSH) begin
                  count_in = '0;
                  state_in = msrt_pkg::ST_DONE;
               end else begin
                  state_in = msrt_pkg::ST_SCAN;
               end
            end
         end
         msrt_pkg::ST_SCAN: begin
            // issue the read, then evaluate it once the registered data is back
            if (pos_ff >= count_ff) begin
               if (msrt_pkg::func_type'(func_ff) == msrt_pkg::FUNC_INSERT) begin
                  if (count_ff == CW'(msrt_pkg::TableDepth)) begin
                     full_in  = 1'b1;
                     state_in = msrt_pkg::ST_DONE;
                  end else begin
                     ip_in    = 32'(pos_ff);
                     pos_in   = count_ff;
                     state_in = msrt_pkg::ST_SHIFT;
                  end
               end else begin
                  state_in = msrt_pkg::ST_DONE;
               end
            end else if (!rd_phase_ff) begin
               rd_phase_in = 1'b1;
            end else begin
               unique case (msrt_pkg::func_type'(func_ff))
                  msrt_pkg::FUNC_LOOKUP: begin
                     if ((ip_ff & rd_data.mask) == rd_data.target) begin
                        hit_in   = 1'b1;
                        res_in   = rd_data;
                        state_in = msrt_pkg::ST_DONE;
                     end else begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end
                  msrt_pkg::FUNC_REMOVE: begin
                     if (exact) begin
                        hit_in   = 1'b1;
                        res_in   = rd_data;
                        count_in = count_ff - 1'b1;
                        pos_in   = pos_ff + 1'b1;
                        state_in = msrt_pkg::ST_SHIFT;
                     end else begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (req_ff.mask > rd_data.mask) begin
                        if (count_ff == CW'(msrt_pkg::TableDepth)) begin
                           full_in  = 1'b1;
                           state_in = msrt_pkg::ST_DONE;
                        end else begin
                           // insertion point found, shift tail up from the end
                           ip_in    = 32'(pos_ff);
                           pos_in   = count_ff;
                           state_in = msrt_pkg::ST_SHIFT;
                        end
                     end else if (exact) begin
                        hit_in      = 1'b1;
                        res_in      = rd_data;
                        res_in.ttl  = req_ff.ttl;
                        wr_en       = 1'b1;
                        wr_data     = rd_data;
                        wr_data.ttl = req_ff.ttl;
                        state_in    = msrt_pkg::ST_DONE;
                     end else begin
                        pos_in = pos_ff + 1'b1;
                        ip_in  = 32'(pos_ff + 1'b1);
                     end
                  end
               endcase
            end
         end
         msrt_pkg::ST_SHIFT: begin
            if (msrt_pkg::func_type'(func_ff) == msrt_pkg::FUNC_REMOVE) begin
               // move slot pos down to pos-1 while pos <= new count
               if (pos_ff > count_ff) begin
                  state_in = msrt_pkg::ST_DONE;
               end else if (!rd_phase_ff) begin
                  rd_phase_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = IW'(pos_ff - 1'b1);
                  wr_data = rd_data;
                  pos_in  = pos_ff + 1'b1;
               end
            end else begin
               // move slot pos-1 up to pos while pos > insertion point
               rd_addr = IW'(pos_ff - 1'b1);
               if (pos_ff == ip_ff[CW-1:0]) begin
                  state_in = msrt_pkg::ST_PLACE;
               end else if (!rd_phase_ff) begin
                  rd_phase_in = 1'b1;
               end else begin
                  wr_en  = 1'b1;
                  wr_data = rd_data;
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         msrt_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_data  = req_ff;
            count_in = count_ff + 1'b1;
            state_in = msrt_pkg::ST_DONE;
         end
         msrt_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = msrt_pkg::ST_IDLE;
            end
         end
         default: state_in = msrt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_found_target  = res_ff.target;
   assign rsp_found_gateway = res_ff.gateway;
   assign rsp_found_mask    = res_ff.mask;
   assign rsp_found_ttl     = res_ff.ttl;
   assign rsp_entry_count   = 6'(count_ff);

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(msrt_pkg::TableDepth))
      else $error("entry count beyond depth");
   a_hit_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(hit_ff && full_ff))
      else $error("hit and full together");
   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == msrt_pkg::ST_DONE)
      else $error("response outside done");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("request taken while response pending");
`endif
endmodule
`default_nettype wire

// ===== rtl/msrt_ram.sv =====
// ----------------------------------------------------------------------------
// msrt_ram: generic single port write, single port read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module msrt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
